FILE: src/rhc_pkg.sv
// Shared types and constants for the RGB/HSV colour converter.
package rhc_pkg;

    // Number of parallel divide lanes and hue sectors
    localparam int LANES   = 3;
    localparam int SECTORS = 6;

    // Lane roles: hue or p, saturation or q, t
    localparam int LANE_HP = 0;
    localparam int LANE_SQ = 1;
    localparam int LANE_T  = 2;

    // Conversion direction held in the mode register
    typedef enum logic
    {
        DIR_TO_HSV = 1'b0,
        DIR_TO_RGB = 1'b1
    } dir_t;

    // Hue sector of the reverse conversion
    typedef enum logic [2:0]
    {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } hue_sector_t;

    // Control that travels with each pixel down the pipeline
    typedef struct packed
    {
        logic        valid;
        dir_t        dir;
        hue_sector_t sector;
    } pix_ctl_t;

endpackage

FILE: src/rhc_prep.sv
// Entry register and operand preparation: extrema, hue sector and divide operands.
module rhc_prep #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             adv,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  rhc_pkg::dir_t                                    dir,
    input  logic [CHANNEL_BITS-1:0]                          in_first,
    input  logic [CHANNEL_BITS-1:0]                          in_second,
    input  logic [CHANNEL_BITS-1:0]                          in_third,
    input  logic [CHANNEL_BITS-1:0]                          in_alpha,
    output rhc_pkg::pix_ctl_t                                ctl,
    output logic [CHANNEL_BITS-1:0]                          alpha,
    output logic [CHANNEL_BITS-1:0]                          val,
    output logic [rhc_pkg::LANES-1:0][CHANNEL_BITS+2:0]      mul_a,
    output logic [rhc_pkg::LANES-1:0][CHANNEL_BITS-1:0]      mul_b,
    output logic [rhc_pkg::LANES-1:0][2*CHANNEL_BITS-1:0]    den
);
    import rhc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int HW = N + 3;
    localparam int DW = 2 * N;
    localparam int SW = $clog2(SECTORS);
    localparam longint unsigned FS_L = (longint'(1) << N) - 1;
    localparam logic [N-1:0]  FS    = N'(FS_L);
    localparam logic [DW-1:0] FS_SQ = DW'(FS_L * FS_L);

    typedef enum logic [1:0]
    {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_ch_t;

    // Entry stage
    logic          v0_reg;
    logic [N-1:0]  a0_reg;
    logic [N-1:0]  b0_reg;
    logic [N-1:0]  c0_reg;
    logic [N-1:0]  al0_reg;
    dir_t          dir0_reg;
    logic          en0;

    // Operand stage
    pix_ctl_t                   ctl_reg;
    pix_ctl_t                   ctl_next;
    logic [N-1:0]               alpha_reg;
    logic [N-1:0]               val_reg;
    logic [N-1:0]               val_next;
    logic [LANES-1:0][HW-1:0]   mul_a_reg;
    logic [LANES-1:0][HW-1:0]   mul_a_next;
    logic [LANES-1:0][N-1:0]    mul_b_reg;
    logic [LANES-1:0][N-1:0]    mul_b_next;
    logic [LANES-1:0][DW-1:0]   den_reg;
    logic [LANES-1:0][DW-1:0]   den_next;

    // Forward working values
    max_ch_t       max_ch;
    logic [N-1:0]  mx;
    logic [N-1:0]  mn;
    logic [N-1:0]  dlt;
    logic [HW-1:0] d6;
    logic [HW-1:0] hn;
    logic [HW-1:0] hden;
    logic [N-1:0]  sden;

    // Reverse working values
    logic [N-1:0]         hw;
    logic [HW-1:0]        x6;
    logic [HW-1:0]        bound [SECTORS];
    logic [SECTORS-1:1]   ge;
    logic [SW-1:0]        sec_idx;
    logic [N-1:0]         fn;

    // Load the entry register whenever it is empty or the pipe moves
    assign en0      = adv || !v0_reg;
    assign in_ready = en0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en0)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0 && in_valid)
        begin
            a0_reg   <= in_first;
            b0_reg   <= in_second;
            c0_reg   <= in_third;
            al0_reg  <= in_alpha;
            dir0_reg <= dir;
        end
    end

    // Sector boundaries k * full scale
    for (genvar k = 0; k < SECTORS; k++)
    begin : g_bound
        assign bound[k] = HW'(longint'(k) * FS_L);
    end

    for (genvar k = 1; k < SECTORS; k++)
    begin : g_ge
        assign ge[k] = x6 >= bound[k];
    end

    // Forward: largest channel picks the sector, red then green win ties
    always_comb
    begin
        if (a0_reg >= b0_reg && a0_reg >= c0_reg)
        begin
            max_ch = MAX_RED;
        end
        else if (b0_reg >= c0_reg)
        begin
            max_ch = MAX_GREEN;
        end
        else
        begin
            max_ch = MAX_BLUE;
        end

        if (a0_reg <= b0_reg && a0_reg <= c0_reg)
        begin
            mn = a0_reg;
        end
        else if (b0_reg <= c0_reg)
        begin
            mn = b0_reg;
        end
        else
        begin
            mn = c0_reg;
        end

        case (max_ch)
            MAX_RED:   mx = a0_reg;
            MAX_GREEN: mx = b0_reg;
            default:   mx = c0_reg;
        endcase

        dlt = mx - mn;
        d6  = (HW'(dlt) << 2) + (HW'(dlt) << 1);

        // Hue numerator base*d + num, always non-negative
        case (max_ch)
            MAX_RED:
            begin
                if (b0_reg >= c0_reg)
                begin
                    hn = HW'(b0_reg) - HW'(c0_reg);
                end
                else
                begin
                    hn = d6 + HW'(b0_reg) - HW'(c0_reg);
                end
            end
            MAX_GREEN: hn = (HW'(dlt) << 1) + HW'(c0_reg) - HW'(a0_reg);
            default:   hn = (HW'(dlt) << 2) + HW'(a0_reg) - HW'(b0_reg);
        endcase

        // Grey pixels divide a zero hue by one; black pixels also divide a zero saturation by one
        hden = (dlt == '0) ? HW'(1) : d6;
        sden = (mx == '0) ? N'(1) : mx;
    end

    // Reverse: wrap hue, find the sector and the fraction within it
    always_comb
    begin
        hw      = (a0_reg == FS) ? '0 : a0_reg;
        x6      = (HW'(hw) << 2) + (HW'(hw) << 1);
        sec_idx = '0;
        for (int k = 1; k < SECTORS; k++)
        begin
            sec_idx = sec_idx + SW'(ge[k]);
        end
        fn = N'(x6 - bound[sec_idx]);
    end

    // Select operands for the three product and divide lanes
    always_comb
    begin
        ctl_next.valid  = v0_reg;
        ctl_next.dir    = dir0_reg;
        ctl_next.sector = SEC_0;
        if (dir0_reg == DIR_TO_HSV)
        begin
            val_next            = mx;
            mul_a_next[LANE_HP] = hn;
            mul_b_next[LANE_HP] = FS;
            mul_a_next[LANE_SQ] = HW'(dlt);
            mul_b_next[LANE_SQ] = FS;
            mul_a_next[LANE_T]  = '0;
            mul_b_next[LANE_T]  = '0;
            den_next[LANE_HP]   = DW'(hden);
            den_next[LANE_SQ]   = DW'(sden);
            den_next[LANE_T]    = DW'(1);
        end
        else
        begin
            ctl_next.sector     = hue_sector_t'(sec_idx);
            val_next            = c0_reg;
            mul_a_next[LANE_HP] = HW'(c0_reg);
            mul_b_next[LANE_HP] = FS - b0_reg;
            mul_a_next[LANE_SQ] = HW'(b0_reg);
            mul_b_next[LANE_SQ] = fn;
            mul_a_next[LANE_T]  = HW'(b0_reg);
            mul_b_next[LANE_T]  = FS - fn;
            den_next[LANE_HP]   = DW'(FS);
            den_next[LANE_SQ]   = FS_SQ;
            den_next[LANE_T]    = FS_SQ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha_reg <= al0_reg;
            val_reg   <= val_next;
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
            den_reg   <= den_next;
        end
    end

    assign ctl   = ctl_reg;
    assign alpha = alpha_reg;
    assign val   = val_reg;
    assign mul_a = mul_a_reg;
    assign mul_b = mul_b_reg;
    assign den   = den_reg;

endmodule

FILE: src/rhc_mult.sv
// Product stages: forms the dividends of the three divide lanes.
module rhc_mult #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             adv,
    input  rhc_pkg::pix_ctl_t                                ctl_in,
    input  logic [CHANNEL_BITS-1:0]                          alpha_in,
    input  logic [CHANNEL_BITS-1:0]                          val_in,
    input  logic [rhc_pkg::LANES-1:0][CHANNEL_BITS+2:0]      mul_a,
    input  logic [rhc_pkg::LANES-1:0][CHANNEL_BITS-1:0]      mul_b,
    input  logic [rhc_pkg::LANES-1:0][2*CHANNEL_BITS-1:0]    den_in,
    output rhc_pkg::pix_ctl_t                                ctl_out,
    output logic [CHANNEL_BITS-1:0]                          alpha_out,
    output logic [CHANNEL_BITS-1:0]                          val_out,
    output logic [rhc_pkg::LANES-1:0][3*CHANNEL_BITS-1:0]    num_out,
    output logic [rhc_pkg::LANES-1:0][2*CHANNEL_BITS-1:0]    den_out
);
    import rhc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int PW = 2 * N + 3;
    localparam int DW = 2 * N;
    localparam int NW = 3 * N;
    localparam longint unsigned FS_L = (longint'(1) << N) - 1;
    localparam logic [PW-1:0] FS_SQ = PW'(FS_L * FS_L);

    // First product stage
    pix_ctl_t                   c2_reg;
    logic [N-1:0]               al2_reg;
    logic [N-1:0]               v2_reg;
    logic [LANES-1:0][PW-1:0]   p2_reg;
    logic [LANES-1:0][PW-1:0]   p2_next;
    logic [LANES-1:0][DW-1:0]   d2_reg;

    // Complement stage
    pix_ctl_t                   c3_reg;
    logic [N-1:0]               al3_reg;
    logic [N-1:0]               v3_reg;
    logic [LANES-1:0][PW-1:0]   x3_reg;
    logic [LANES-1:0][PW-1:0]   x3_next;
    logic [LANES-1:0][DW-1:0]   d3_reg;

    // Second product stage
    pix_ctl_t                   c4_reg;
    logic [N-1:0]               al4_reg;
    logic [N-1:0]               v4_reg;
    logic [LANES-1:0][NW-1:0]   n4_reg;
    logic [LANES-1:0][NW-1:0]   n4_next;
    logic [LANES-1:0][DW-1:0]   d4_reg;

    // Lane products: hue or d times full scale, or the HSV partial products
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            p2_next[l] = PW'(mul_a[l]) * PW'(mul_b[l]);
        end
    end

    // Reverse q and t lanes take full scale squared minus the product
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (l != LANE_HP && c2_reg.dir == DIR_TO_RGB)
            begin
                x3_next[l] = FS_SQ - p2_reg[l];
            end
            else
            begin
                x3_next[l] = p2_reg[l];
            end
        end
    end

    // Reverse q and t lanes scale by value
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (l != LANE_HP && c3_reg.dir == DIR_TO_RGB)
            begin
                n4_next[l] = NW'(v3_reg) * NW'(x3_reg[l][DW-1:0]);
            end
            else
            begin
                n4_next[l] = NW'(x3_reg[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (adv)
        begin
            c2_reg <= ctl_in;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            al2_reg <= alpha_in;
            v2_reg  <= val_in;
            p2_reg  <= p2_next;
            d2_reg  <= den_in;
            al3_reg <= al2_reg;
            v3_reg  <= v2_reg;
            x3_reg  <= x3_next;
            d3_reg  <= d2_reg;
            al4_reg <= al3_reg;
            v4_reg  <= v3_reg;
            n4_reg  <= n4_next;
            d4_reg  <= d3_reg;
        end
    end

    assign ctl_out   = c4_reg;
    assign alpha_out = al4_reg;
    assign val_out   = v4_reg;
    assign num_out   = n4_reg;
    assign den_out   = d4_reg;

endmodule

FILE: src/rhc_div.sv
// Pipelined restoring divider: three lanes, one quotient bit per stage.
module rhc_div #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             adv,
    input  rhc_pkg::pix_ctl_t                                ctl_in,
    input  logic [CHANNEL_BITS-1:0]                          alpha_in,
    input  logic [CHANNEL_BITS-1:0]                          val_in,
    input  logic [rhc_pkg::LANES-1:0][3*CHANNEL_BITS-1:0]    num_in,
    input  logic [rhc_pkg::LANES-1:0][2*CHANNEL_BITS-1:0]    den_in,
    output rhc_pkg::pix_ctl_t                                ctl_out,
    output logic [CHANNEL_BITS-1:0]                          alpha_out,
    output logic [CHANNEL_BITS-1:0]                          val_out,
    output logic [rhc_pkg::LANES-1:0][CHANNEL_BITS-1:0]      quo_out
);
    import rhc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int DW = 2 * N;
    localparam int NW = 3 * N;

    // Stage registers; remainder and divisor are not kept after the last stage
    pix_ctl_t                   ctl_reg   [N];
    logic [N-1:0]               alpha_reg [N];
    logic [N-1:0]               val_reg   [N];
    logic [LANES-1:0][N-1:0]    quo_reg   [N];
    logic [LANES-1:0][NW-1:0]   rem_reg   [N-1];
    logic [LANES-1:0][DW-1:0]   den_reg   [N-1];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam int SH = N - 1 - s;

        pix_ctl_t                   ctl_src;
        logic [N-1:0]               alpha_src;
        logic [N-1:0]               val_src;
        logic [LANES-1:0][N-1:0]    quo_src;
        logic [LANES-1:0][N-1:0]    quo_next;
        logic [LANES-1:0][NW-1:0]   rem_src;
        logic [LANES-1:0][NW-1:0]   trial;
        logic [LANES-1:0][DW-1:0]   den_src;
        logic [LANES-1:0]           take;

        // Feed from the product stages or from the previous bit stage
        if (s == 0)
        begin : g_head
            assign ctl_src   = ctl_in;
            assign alpha_src = alpha_in;
            assign val_src   = val_in;
            assign quo_src   = '0;
            assign rem_src   = num_in;
            assign den_src   = den_in;
        end
        else
        begin : g_body
            assign ctl_src   = ctl_reg[s-1];
            assign alpha_src = alpha_reg[s-1];
            assign val_src   = val_reg[s-1];
            assign quo_src   = quo_reg[s-1];
            assign rem_src   = rem_reg[s-1];
            assign den_src   = den_reg[s-1];
        end

        // Try the divisor shifted to this bit and keep the quotient bit
        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[l]        = NW'(den_src[l]) << SH;
                take[l]         = rem_src[l] >= trial[l];
                quo_next[l]     = quo_src[l];
                quo_next[l][SH] = take[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[s] <= ctl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                alpha_reg[s] <= alpha_src;
                val_reg[s]   <= val_src;
                quo_reg[s]   <= quo_next;
            end
        end

        // Subtract where the bit was set and carry the remainder on
        if (s < N - 1)
        begin : g_keep
            logic [LANES-1:0][NW-1:0] rem_next;

            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_next[l] = take[l] ? (rem_src[l] - trial[l]) : rem_src[l];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_src;
                end
            end
        end
    end

    assign ctl_out   = ctl_reg[N-1];
    assign alpha_out = alpha_reg[N-1];
    assign val_out   = val_reg[N-1];
    assign quo_out   = quo_reg[N-1];

endmodule

FILE: src/rgb_hsv_convert.sv
// RGB to HSV and HSV to RGB pixel converter, top level.
// Path: entry and operand registers, product stages, divider bit stages, output register.
// Throughput: one pixel per cycle; the restoring divider resolves one quotient bit per stage.
// A stalled output holds the whole pipe; the entry register still takes a pixel while empty.
// Reset clears all valid bits and sets the mode register to RGB to HSV.
module rgb_hsv_convert #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CHANNEL_BITS-1:0]  in_first,
    input  logic [CHANNEL_BITS-1:0]  in_second,
    input  logic [CHANNEL_BITS-1:0]  in_third,
    input  logic [CHANNEL_BITS-1:0]  in_alpha,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CHANNEL_BITS-1:0]  out_first,
    output logic [CHANNEL_BITS-1:0]  out_second,
    output logic [CHANNEL_BITS-1:0]  out_third,
    output logic [CHANNEL_BITS-1:0]  out_alpha
);
    import rhc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int HW = N + 3;
    localparam int DW = 2 * N;
    localparam int NW = 3 * N;

    dir_t                       direction_reg;
    logic                       adv;

    pix_ctl_t                   prep_ctl;
    logic [N-1:0]               prep_alpha;
    logic [N-1:0]               prep_val;
    logic [LANES-1:0][HW-1:0]   prep_mul_a;
    logic [LANES-1:0][N-1:0]    prep_mul_b;
    logic [LANES-1:0][DW-1:0]   prep_den;

    pix_ctl_t                   mult_ctl;
    logic [N-1:0]               mult_alpha;
    logic [N-1:0]               mult_val;
    logic [LANES-1:0][NW-1:0]   mult_num;
    logic [LANES-1:0][DW-1:0]   mult_den;

    pix_ctl_t                   div_ctl;
    logic [N-1:0]               div_alpha;
    logic [N-1:0]               div_val;
    logic [LANES-1:0][N-1:0]    div_quo;

    logic                       out_valid_reg;
    logic [N-1:0]               out_first_reg;
    logic [N-1:0]               out_first_next;
    logic [N-1:0]               out_second_reg;
    logic [N-1:0]               out_second_next;
    logic [N-1:0]               out_third_reg;
    logic [N-1:0]               out_third_next;
    logic [N-1:0]               out_alpha_reg;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_TO_HSV;
        end
        else if (cfg_wr_en)
        begin
            direction_reg <= dir_t'(cfg_wr_data);
        end
    end

    // Advance the pipe unless a finished transaction waits at the output
    assign adv = !out_valid_reg || out_ready;

    rhc_prep #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dir       (direction_reg),
        .in_first  (in_first),
        .in_second (in_second),
        .in_third  (in_third),
        .in_alpha  (in_alpha),
        .ctl       (prep_ctl),
        .alpha     (prep_alpha),
        .val       (prep_val),
        .mul_a     (prep_mul_a),
        .mul_b     (prep_mul_b),
        .den       (prep_den)
    );

    rhc_mult #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (prep_ctl),
        .alpha_in  (prep_alpha),
        .val_in    (prep_val),
        .mul_a     (prep_mul_a),
        .mul_b     (prep_mul_b),
        .den_in    (prep_den),
        .ctl_out   (mult_ctl),
        .alpha_out (mult_alpha),
        .val_out   (mult_val),
        .num_out   (mult_num),
        .den_out   (mult_den)
    );

    rhc_div #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (mult_ctl),
        .alpha_in  (mult_alpha),
        .val_in    (mult_val),
        .num_in    (mult_num),
        .den_in    (mult_den),
        .ctl_out   (div_ctl),
        .alpha_out (div_alpha),
        .val_out   (div_val),
        .quo_out   (div_quo)
    );

    // Route quotients and value to the output channels
    always_comb
    begin
        out_first_next  = div_quo[LANE_HP];
        out_second_next = div_quo[LANE_SQ];
        out_third_next  = div_val;
        if (div_ctl.dir == DIR_TO_RGB)
        begin
            unique case (div_ctl.sector)
                SEC_0:
                begin
                    out_first_next  = div_val;
                    out_second_next = div_quo[LANE_T];
                    out_third_next  = div_quo[LANE_HP];
                end
                SEC_1:
                begin
                    out_first_next  = div_quo[LANE_SQ];
                    out_second_next = div_val;
                    out_third_next  = div_quo[LANE_HP];
                end
                SEC_2:
                begin
                    out_first_next  = div_quo[LANE_HP];
                    out_second_next = div_val;
                    out_third_next  = div_quo[LANE_T];
                end
                SEC_3:
                begin
                    out_first_next  = div_quo[LANE_HP];
                    out_second_next = div_quo[LANE_SQ];
                    out_third_next  = div_val;
                end
                SEC_4:
                begin
                    out_first_next  = div_quo[LANE_T];
                    out_second_next = div_quo[LANE_HP];
                    out_third_next  = div_val;
                end
                SEC_5:
                begin
                    out_first_next  = div_val;
                    out_second_next = div_quo[LANE_HP];
                    out_third_next  = div_quo[LANE_SQ];
                end
                default:
                begin
                    out_first_next  = div_val;
                    out_second_next = div_val;
                    out_third_next  = div_val;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && div_ctl.valid)
        begin
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_third_reg  <= out_third_next;
            out_alpha_reg  <= div_alpha;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_third  = out_third_reg;
    assign out_alpha  = out_alpha_reg;

endmodule

FILE: src/rhc_checker.sv
// Port-level checks for the colour converter, bound to the top level.
module rhc_checker #(
    parameter int CHANNEL_BITS = 12
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [CHANNEL_BITS-1:0]  out_first,
    input logic [CHANNEL_BITS-1:0]  out_second,
    input logic [CHANNEL_BITS-1:0]  out_third,
    input logic [CHANNEL_BITS-1:0]  out_alpha
);

    // Reset empties the output stage by the following edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high after reset");

    // A free output side never blocks the input side
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled while output side can move");

    // Handshake signals stay known once out of reset
    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_ready, out_valid, out_ready}))
        else $error("unknown value on a handshake signal");

    // A waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first)
        && $stable(out_second) && $stable(out_third) && $stable(out_alpha))
        else $error("output transaction changed while stalled");

endmodule

bind rgb_hsv_convert rhc_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_rhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_first  (out_first),
    .out_second (out_second),
    .out_third  (out_third),
    .out_alpha  (out_alpha)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the RGB/HSV pixel converter with a built-in pixel predictor.
module tb_top;

    import rhc_pkg::*;

    localparam int     CB          = 12;
    localparam longint FS          = (longint'(1) << CB) - 1;
    localparam longint FS_SQ       = FS * FS;
    localparam int     HOLD_CYCLES = 80;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PHASE_ITEMS = 200;

    typedef struct packed
    {
        logic [CB-1:0] first;
        logic [CB-1:0] second;
        logic [CB-1:0] third;
        logic [CB-1:0] alpha;
    } pixel_t;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          cfg_wr_en   = 1'b0;
    logic          cfg_wr_data = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_ready;
    logic [CB-1:0] in_first    = '0;
    logic [CB-1:0] in_second   = '0;
    logic [CB-1:0] in_third    = '0;
    logic [CB-1:0] in_alpha    = '0;
    logic          out_valid;
    logic          out_ready   = 1'b0;
    logic [CB-1:0] out_first;
    logic [CB-1:0] out_second;
    logic [CB-1:0] out_third;
    logic [CB-1:0] out_alpha;

    pixel_t pixel_queue[$];
    pixel_t due_pixels[$];
    dir_t   mode_shadow   = DIR_TO_HSV;
    logic   in_taken_last = 1'b0;
    int     pixels_queued = 0;
    int     pixels_taken  = 0;
    int     fault_count   = 0;
    int     cycle_count   = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     hold_req      = 1'b0;
    bit     hold_ack      = 1'b0;
    int     hold_left     = 0;

    rgb_hsv_convert #(
        .CHANNEL_BITS (CB)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_first    (in_first),
        .in_second   (in_second),
        .in_third    (in_third),
        .in_alpha    (in_alpha),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_first   (out_first),
        .out_second  (out_second),
        .out_third   (out_third),
        .out_alpha   (out_alpha)
    );

    always #5 clk = ~clk;

    // Forward conversion: hue sector from the largest channel, red winning ties, then green
    function automatic pixel_t rgb_to_hsv(pixel_t px);
        longint r, g, b, mx, mn, d, base, num, hue, sat;
        pixel_t res;
        r = px.first;
        g = px.second;
        b = px.third;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hue = 0;
        sat = 0;
        if (d != 0)
        begin
            if (mx == r)
            begin
                num  = g - b;
                base = (num < 0) ? 6 : 0;
            end
            else if (mx == g)
            begin
                num  = b - r;
                base = 2;
            end
            else
            begin
                num  = r - g;
                base = 4;
            end
            hue = ((base * d + num) * FS) / (6 * d);
        end
        if (mx != 0)
            sat = (d * FS) / mx;
        res.first  = CB'(hue);
        res.second = CB'(sat);
        res.third  = CB'(mx);
        res.alpha  = px.alpha;
        return res;
    endfunction

    // Reverse conversion: six sectors, truncated p, q and t products
    function automatic pixel_t hsv_to_rgb(pixel_t px);
        longint h, s, v, x, fn, p, q, t;
        hue_sector_t sec;
        pixel_t res;
        h = px.first;
        s = px.second;
        v = px.third;
        if (h >= FS)
            h = 0;
        x   = 6 * h;
        sec = hue_sector_t'(x / FS);
        fn  = x % FS;
        p   = (v * (FS - s)) / FS;
        q   = (v * (FS_SQ - s * fn)) / FS_SQ;
        t   = (v * (FS_SQ - s * (FS - fn))) / FS_SQ;
        res.alpha = px.alpha;
        case (sec)
            SEC_0:   {res.first, res.second, res.third} = {CB'(v), CB'(t), CB'(p)};
            SEC_1:   {res.first, res.second, res.third} = {CB'(q), CB'(v), CB'(p)};
            SEC_2:   {res.first, res.second, res.third} = {CB'(p), CB'(v), CB'(t)};
            SEC_3:   {res.first, res.second, res.third} = {CB'(p), CB'(q), CB'(v)};
            SEC_4:   {res.first, res.second, res.third} = {CB'(t), CB'(p), CB'(v)};
            default: {res.first, res.second, res.third} = {CB'(v), CB'(p), CB'(q)};
        endcase
        return res;
    endfunction

    function automatic int rand_chan();
        return $urandom_range(0, FS);
    endfunction

    // Random RGB pixel, biased towards greys, ties, black and saturated channels
    function automatic pixel_t random_rgb();
        pixel_t px;
        int top;
        top = rand_chan();
        px.first  = CB'(rand_chan());
        px.second = CB'(rand_chan());
        px.third  = CB'(rand_chan());
        px.alpha  = CB'(rand_chan());
        case ($urandom_range(0, 9))
            0: {px.first, px.second, px.third} = {CB'(top), CB'(top), CB'(top)};
            1: {px.first, px.second, px.third} = {CB'(top), CB'(top), CB'($urandom_range(0, top))};
            2: {px.first, px.second, px.third} = {CB'($urandom_range(0, top)), CB'(top), CB'(top)};
            3: {px.first, px.second, px.third} = {CB'(top), CB'($urandom_range(0, top)), CB'(top)};
            4: {px.first, px.second, px.third} = {CB'($urandom_range(0, 15)),
                                                  CB'($urandom_range(0, 15)),
                                                  CB'($urandom_range(0, 15))};
            5: px.second = '0;
            6: px.first  = CB'(FS);
            default: ;
        endcase
        return px;
    endfunction

    // Random HSV pixel, biased towards sector edges, the wrapping hue and extreme s and v
    function automatic pixel_t random_hsv();
        pixel_t px;
        longint h;
        px.alpha = CB'(rand_chan());
        case ($urandom_range(0, 5))
            0: h = FS;
            1:
            begin
                h = ($urandom_range(0, 6) * FS) / 6 + $urandom_range(0, 2) - 1;
                if (h < 0) h = 0;
                if (h > FS) h = FS;
            end
            default: h = rand_chan();
        endcase
        px.first = CB'(h);
        case ($urandom_range(0, 5))
            0:       px.second = '0;
            1:       px.second = CB'(FS);
            default: px.second = CB'(rand_chan());
        endcase
        case ($urandom_range(0, 5))
            0:       px.third = '0;
            1:       px.third = CB'(FS);
            default: px.third = CB'(rand_chan());
        endcase
        return px;
    endfunction

    task automatic check_field(string label, logic [CB-1:0] want, logic [CB-1:0] got);
        if (want !== got)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Advance the pixel source: hold an offered transaction until it is taken
    always @(negedge clk)
    begin : drive_pixels
        pixel_t nxt;
        if (in_valid && !in_taken_last)
        begin
        end
        else if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        begin
            nxt       = pixel_queue.pop_front();
            in_first  <= nxt.first;
            in_second <= nxt.second;
            in_third  <= nxt.third;
            in_alpha  <= nxt.alpha;
            in_valid  <= 1'b1;
        end
        else
            in_valid <= 1'b0;
    end

    // Drive the sink ready, with a long hold-off whenever one is requested
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin : watch_ports
        pixel_t got, want, seen;
        in_taken_last <= in_valid && in_ready && rst_n;
        if (rst_n)
        begin
            if (cfg_wr_en)
                mode_shadow <= dir_t'(cfg_wr_data);
            if (in_valid && in_ready)
            begin
                seen = '{in_first, in_second, in_third, in_alpha};
                due_pixels.push_back(mode_shadow == DIR_TO_RGB ? hsv_to_rgb(seen)
                                                               : rgb_to_hsv(seen));
                pixels_taken++;
            end
            if (out_valid && out_ready)
            begin
                got = '{out_first, out_second, out_third, out_alpha};
                if (due_pixels.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = due_pixels.pop_front();
                    check_field("out_first",  want.first,  got.first);
                    check_field("out_second", want.second, got.second);
                    check_field("out_third",  want.third,  got.third);
                    check_field("out_alpha",  want.alpha,  got.alpha);
                end
            end
        end
    end

    task automatic queue_pixel(int f, int s, int t, int a);
        pixel_queue.push_back('{CB'(f), CB'(s), CB'(t), CB'(a)});
        pixels_queued++;
    endtask

    task automatic wait_idle();
        while (pixels_taken != pixels_queued || due_pixels.size() != 0)
            @(negedge clk);
    endtask

    // Write the mode register for one cycle while the pipe is empty
    task automatic write_mode(dir_t mode);
        wait_idle();
        @(negedge clk);
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(dir_t mode, int count, bit squeeze);
        pixel_t px;
        write_mode(mode);
        for (int i = 0; i < count; i++)
        begin
            px = (mode == DIR_TO_RGB) ? random_hsv() : random_rgb();
            queue_pixel(px.first, px.second, px.third, px.alpha);
        end
        if (squeeze)
            hold_req = ~hold_req;
        wait_idle();
    endtask

    // Main sequence
    initial
    begin
        send_idle_pct = 34;
        recv_idle_pct = 75;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Forward corners with the mode left at its reset value
        queue_pixel(0,    0,    0,    0);
        queue_pixel(4095, 4095, 4095, 4095);
        queue_pixel(4095, 0,    0,    1234);
        queue_pixel(0,    4095, 0,    4095);
        queue_pixel(0,    0,    4095, 0);
        queue_pixel(4095, 4095, 0,    2730);
        queue_pixel(0,    4095, 4095, 1);
        queue_pixel(4095, 0,    4095, 2048);
        queue_pixel(4095, 0,    1,    3000);
        queue_pixel(1,    0,    0,    5);
        queue_pixel(100,  200,  50,   77);
        queue_pixel(2048, 2048, 2048, 4094);

        // Reverse corners: sector edges, wrapping hue, zero saturation and value
        write_mode(DIR_TO_RGB);
        queue_pixel(0,    4095, 4095, 0);
        queue_pixel(4095, 4095, 4095, 4095);
        queue_pixel(682,  4095, 4095, 1);
        queue_pixel(683,  4095, 4095, 2);
        queue_pixel(1365, 4095, 4095, 3);
        queue_pixel(1366, 4095, 2048, 4);
        queue_pixel(2047, 4095, 4095, 5);
        queue_pixel(2048, 2000, 4095, 6);
        queue_pixel(2730, 4095, 4095, 7);
        queue_pixel(3413, 4095, 4095, 8);
        queue_pixel(4094, 4095, 4095, 9);
        queue_pixel(1000, 0,    3000, 10);
        queue_pixel(1500, 4095, 0,    11);

        random_phase(DIR_TO_HSV, PHASE_ITEMS, 1'b0);
        random_phase(DIR_TO_RGB, PHASE_ITEMS, 1'b0);

        send_idle_pct = 75;
        recv_idle_pct = 34;
        random_phase(DIR_TO_HSV, PHASE_ITEMS, 1'b0);
        random_phase(DIR_TO_RGB, PHASE_ITEMS, 1'b0);

        // Back-to-back traffic, with the sink held off in the forward phase long enough to fill the pipe
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(DIR_TO_HSV, PHASE_ITEMS, 1'b1);
        random_phase(DIR_TO_RGB, PHASE_ITEMS, 1'b0);

        wait_idle();
        repeat (CB + 40) @(negedge clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/rhc_pkg.sv
src/rhc_prep.sv
src/rhc_mult.sv
src/rhc_div.sv
src/rgb_hsv_convert.sv
src/rhc_checker.sv
dv/tb_top.sv
